// ----- rtl/core/rpn_pkg.sv -----
// Package for the postfix stack evaluator.
// Holds field widths, token and status codes, sequencer states and divider structs.
// No dependencies.
package rpn_pkg;

    localparam int DATA_W     = 32;
    localparam int MODE_W     = 4;
    localparam int ARG_W      = 7;
    localparam int STATUS_W   = 2;
    localparam int DIV_STEP_W = $clog2(DATA_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH = 4'd0,
        MODE_ADD  = 4'd1,
        MODE_SUB  = 4'd2,
        MODE_MUL  = 4'd3,
        MODE_DIV  = 4'd4,
        MODE_NEG  = 4'd5,
        MODE_IF   = 4'd6,
        MODE_MIN  = 4'd7,
        MODE_MAX  = 4'd8,
        MODE_END  = 4'd9
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_EXEC,
        S_DIV,
        S_PUSH,
        S_END
    } state_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/rpn_tok_if.sv -----
// Token channel: valid/ready handshake carrying one postfix token.
// Depends on rpn_pkg.
interface rpn_tok_if import rpn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] number;
    logic [ARG_W-1:0]         arg_count;

    modport source (output valid, mode, number, arg_count, input ready);
    modport sink   (input valid, mode, number, arg_count, output ready);
endinterface

// ----- rtl/core/rpn_res_if.sv -----
// Result channel: valid/ready handshake carrying the value and status of an expression.
// Depends on rpn_pkg.
interface rpn_res_if import rpn_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

// ----- rtl/core/rpn_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rpn_pkg.
module rpn_div import rpn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [DIV_STEP_W-1:0] step_reg,  step_next;
    logic [DATA_W:0]       rem_reg,   rem_next;
    logic [DATA_W-1:0]     quo_reg,   quo_next;
    logic [DATA_W-1:0]     dvs_reg,   dvs_next;
    logic                  neg_reg,   neg_next;
    logic [DATA_W:0]       shifted;
    logic [DATA_W:0]       diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg[DATA_W-1:0], quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = DIV_STEP_W'(DATA_W - 1);
            rem_next  = '0;
            quo_next  = req.dividend[DATA_W-1] ? (DATA_W'(0) - req.dividend) : req.dividend;
            dvs_next  = req.divisor[DATA_W-1] ? (DATA_W'(0) - req.divisor) : req.divisor;
            neg_next  = req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;

endmodule

// ----- rtl/core/rpn_stack_evaluator.sv -----
// Postfix evaluator: a push writes the stack directly; an operator reads its n values
// one by one (S_POP), computes (S_EXEC) and pushes (S_PUSH); divide runs the iterative
// divider (one bit a cycle). End loads the result register; it waits while one is pending.
// One token at a time; the stack memory port and the sequencer set the rate.
// Reset clears the stack count, error flags and output valid; stack contents stay unset.
module rpn_stack_evaluator import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    rpn_tok_if.sink    tok,
    rpn_res_if.source  res
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;

    state_t            state_reg,   state_next;
    mode_t             mode_reg,    mode_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              div_err_reg, div_err_next;
    logic              over_reg,    over_next;
    logic [ARG_W-1:0]  remain_reg,  remain_next;
    logic              pend_reg,    pend_next;
    logic              pzero_reg,   pzero_next;
    logic [1:0]        take_reg,    take_next;
    logic [DATA_W-1:0] op_a_reg,    op_a_next;
    logic [DATA_W-1:0] op_b_reg,    op_b_next;
    logic [DATA_W-1:0] op_c_reg,    op_c_next;
    logic [DATA_W-1:0] result_reg,  result_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    status_t           out_status_reg, out_status_next;

    logic [DATA_W-1:0] pop_v;
    logic [CNT_W-1:0]  count_dec;
    logic              full;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    rpn_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (rd_en)
            rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            div_err_reg   <= 1'b0;
            over_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            div_err_reg   <= div_err_next;
            over_reg      <= over_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        remain_reg     <= remain_next;
        pzero_reg      <= pzero_next;
        take_reg       <= take_next;
        op_a_reg       <= op_a_next;
        op_b_reg       <= op_b_next;
        op_c_reg       <= op_c_next;
        result_reg     <= result_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign count_dec = count_reg - 1'b1;
    assign full      = (count_reg >= CNT_W'(STACK_DEPTH));
    assign pop_v     = pzero_reg ? '0 : rd_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        div_err_next    = div_err_reg;
        over_next       = over_reg;
        remain_next     = remain_reg;
        pend_next       = 1'b0;
        pzero_next      = pzero_reg;
        take_next       = take_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        op_c_next       = op_c_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg && !res.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        raddr           = count_dec[ADDR_W-1:0];
        we              = 1'b0;
        waddr           = count_reg[ADDR_W-1:0];
        wdata           = tok.number;
        div_req.start    = 1'b0;
        div_req.dividend = op_b_reg;
        div_req.divisor  = op_a_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (tok.valid)
                begin
                    if (tok.mode == MODE_END)
                    begin
                        rd_en      = (count_reg != '0);
                        state_next = S_END;
                    end
                    else if (!div_err_reg)
                    begin
                        mode_next = mode_t'(tok.mode);
                        take_next = 2'd0;
                        case (tok.mode)
                            MODE_PUSH:
                            begin
                                if (full)
                                    over_next = 1'b1;
                                else
                                begin
                                    we         = 1'b1;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV:
                            begin
                                remain_next = ARG_W'(2);
                                state_next  = S_POP;
                            end
                            MODE_NEG:
                            begin
                                remain_next = ARG_W'(1);
                                state_next  = S_POP;
                            end
                            MODE_IF:
                            begin
                                remain_next = ARG_W'(3);
                                state_next  = S_POP;
                            end
                            MODE_MIN, MODE_MAX:
                            begin
                                remain_next = (tok.arg_count == '0) ? ARG_W'(1) : tok.arg_count;
                                state_next  = S_POP;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end

            S_POP:
            begin
                // consume the value read in the previous cycle
                if (pend_reg)
                begin
                    if (take_reg != 2'd3)
                        take_next = take_reg + 1'b1;
                    if (mode_reg == MODE_MIN || mode_reg == MODE_MAX)
                    begin
                        if (take_reg == 2'd0)
                            op_a_next = pop_v;
                        else if (mode_reg == MODE_MIN && $signed(pop_v) < $signed(op_a_reg))
                            op_a_next = pop_v;
                        else if (mode_reg == MODE_MAX && $signed(op_a_reg) < $signed(pop_v))
                            op_a_next = pop_v;
                    end
                    else
                    begin
                        case (take_reg)
                            2'd0:    op_a_next = pop_v;
                            2'd1:    op_b_next = pop_v;
                            default: op_c_next = pop_v;
                        endcase
                    end
                end
                // issue the next pop
                if (remain_reg != '0)
                begin
                    pend_next   = 1'b1;
                    pzero_next  = (count_reg == '0);
                    remain_next = remain_reg - 1'b1;
                    if (count_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        count_next = count_dec;
                    end
                end
                else if (!pend_reg)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_PUSH;
                case (mode_reg)
                    MODE_ADD: result_next = op_b_reg + op_a_reg;
                    MODE_SUB: result_next = op_b_reg - op_a_reg;
                    MODE_MUL: result_next = op_b_reg * op_a_reg;
                    MODE_NEG: result_next = DATA_W'(0) - op_a_reg;
                    MODE_IF:
                        result_next = (!op_c_reg[DATA_W-1] && op_c_reg != '0) ? op_b_reg : op_a_reg;
                    MODE_MIN, MODE_MAX: result_next = op_a_reg;
                    MODE_DIV:
                    begin
                        if (op_a_reg == '0)
                        begin
                            div_err_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            div_req.start = 1'b1;
                            state_next    = S_DIV;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    result_next = div_rsp.quotient;
                    state_next  = S_PUSH;
                end
            end

            S_PUSH:
            begin
                wdata = result_reg;
                if (full)
                    over_next = 1'b1;
                else
                begin
                    we         = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_IDLE;
            end

            S_END:
            begin
                // hold until the result register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    if (div_err_reg)
                        out_status_next = ST_DIV0;
                    else if (over_reg)
                        out_status_next = ST_OVER;
                    else if (count_reg == '0)
                        out_status_next = ST_EMPTY;
                    else
                    begin
                        out_status_next = ST_OK;
                        out_value_next  = rd_data_reg;
                    end
                    count_next   = '0;
                    div_err_next = 1'b0;
                    over_next    = 1'b0;
                    state_next   = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    assign tok.ready        = (state_reg == S_IDLE);
    assign res.valid        = out_valid_reg;
    assign res.result_value = out_value_reg;
    assign res.status       = out_status_reg;

endmodule

// ----- rtl/core/rpn_checker.sv -----
// Port-level checks on the postfix evaluator, and the bind that attaches them.
// Depends on rpn_pkg and rpn_stack_evaluator.
module rpn_checker import rpn_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                tok_valid,
    input logic                tok_ready,
    input logic [MODE_W-1:0]   tok_mode,
    input logic                res_valid,
    input logic                res_ready,
    input logic [DATA_W-1:0]   res_value,
    input logic [STATUS_W-1:0] res_status
);

    // hold a stalled result transaction
    ap_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_status))
        else $error("result changed while stalled");

    ap_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_value == '0)
        else $error("error result carries a nonzero value");

    ap_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready && tok_mode == MODE_END |=> !tok_ready)
        else $error("token taken while an end transaction completes");

    ap_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready && tok_mode != MODE_END && !res_valid |=> !res_valid)
        else $error("result raised without an end transaction");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .tok_valid  (tok.valid),
    .tok_ready  (tok.ready),
    .tok_mode   (tok.mode),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_value  (res.result_value),
    .res_status (res.status)
);
